@@ hdl/pid_rdm_pkg.sv @@
// -----------------------------------------------------------------------------
// pid_rdm_pkg
// Shared types and constants for the dual-mode PID regulator: sample and
// result transfer structs and fixed-point widths.
// -----------------------------------------------------------------------------
package pid_rdm_pkg;

  // fixed-point format of integral and output accumulators
  localparam int unsigned FracBits = 8;

  // datapath widths
  localparam int unsigned SampleW  = 16;
  localparam int unsigned ErrW     = 17;
  localparam int unsigned GainW    = 16;
  localparam int unsigned LimitW   = 20;
  localparam int unsigned DeadW    = 16;
  localparam int unsigned IntegW   = 48;
  localparam int unsigned OutAccW  = 32;
  localparam int unsigned DriveW   = 21;
  localparam int unsigned SumW     = 40;

  // configuration port
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;

  // one input sample pair
  typedef struct packed {
    logic signed [SampleW-1:0] reference;
    logic signed [SampleW-1:0] feedback;
  } pid_in_t;

  // one regulator result
  typedef struct packed {
    logic signed [DriveW-1:0] drive;
    logic                     held;
  } pid_out_t;

endpackage

@@ hdl/pid_regulator_dual_mode_unit.sv @@
// -----------------------------------------------------------------------------
// pid_regulator_dual_mode_unit
// Fixed-point PID regulator with positional and incremental forms, dead zone,
// integral clamp and output clamp, fed by reference/feedback sample pairs.
// -----------------------------------------------------------------------------
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-------------------------
//  in       | input     | in_valid_i / in_stall_o   | reference, feedback
//  out      | output    | out_valid_o / out_stall_i | drive, held
//  apb      | input     | psel, penable, pready     | paddr, pwdata, prdata
//
//  one sample per clock sustained while out_stall_i is low; a sample passes
//  through the input register and then into the result register.
//  the three gain multipliers and the accumulator update sit in one stage,
//  which is what closes the loop for the next sample.
//  reset clears all gains, limits, error history and accumulators.
//  a stalled result holds in the result register while one more sample waits
//  in the input register; only then is in_stall_o raised.
//
module pid_regulator_dual_mode_unit
  import pid_rdm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // sample input
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pid_in_t             in_data_i,
  // result output
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pid_out_t            out_data_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  typedef enum logic [2:0] {
    RegMode      = 3'd0,
    RegGainP     = 3'd1,
    RegGainI     = 3'd2,
    RegGainD     = 3'd3,
    RegIntegLim  = 3'd4,
    RegDeadZone  = 3'd5,
    RegOutMax    = 3'd6
  } cfg_reg_e;

  // configuration registers
  logic                     mode_q;
  logic signed [GainW-1:0]  gain_p_q, gain_i_q, gain_d_q;
  logic        [LimitW-1:0] integ_lim_q;
  logic        [DeadW-1:0]  dead_zone_q;
  logic        [LimitW-1:0] out_max_q;

  // regulator state
  logic signed [ErrW-1:0]    err0_q, err1_q;
  logic signed [IntegW-1:0]  integ_q;
  logic signed [OutAccW-1:0] out_acc_q;

  // pipeline registers
  logic     in_valid_q;
  pid_in_t  in_q;
  logic     out_valid_q;
  pid_out_t out_q;

  // datapath
  logic signed [ErrW-1:0]     err;
  logic signed [ErrW:0]       diff1;
  logic signed [ErrW+1:0]     diff2;
  logic signed [ErrW:0]       op_p;
  logic signed [ErrW+1:0]     op_d;
  logic signed [ErrW+GainW:0]   prod_p;
  logic signed [ErrW+GainW-1:0] prod_i;
  logic signed [ErrW+GainW+1:0] prod_d;
  logic signed [IntegW:0]     integ_sum;
  logic signed [IntegW-1:0]   integ_sat;
  logic signed [IntegW-1:0]   integ_lim;
  logic signed [IntegW-1:0]   integ_clamp;
  logic signed [IntegW-1:0]   integ_d;
  logic signed [ErrW:0]       dz_ext;
  logic                       held;
  logic signed [SumW-1:0]     out_max_fx;
  logic signed [SumW-1:0]     sum_v;
  logic signed [SumW-1:0]     sum_clamp;
  logic signed [SumW-1:0]     out_lo, out_hi;
  logic signed [OutAccW-1:0]  out_acc_d;
  logic signed [OutAccW-1:0]  out_acc_new;
  logic signed [OutAccW-1:0]  drive_shift;
  logic                       out_ready;
  logic                       move;
  logic                       cfg_wr;
  cfg_reg_e                   cfg_idx;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = cfg_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      integ_lim_q <= '0;
      dead_zone_q <= '0;
      out_max_q   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegMode:     mode_q      <= pwdata[0];
        RegGainP:    gain_p_q    <= signed'(pwdata[GainW-1:0]);
        RegGainI:    gain_i_q    <= signed'(pwdata[GainW-1:0]);
        RegGainD:    gain_d_q    <= signed'(pwdata[GainW-1:0]);
        RegIntegLim: integ_lim_q <= pwdata[LimitW-1:0];
        RegDeadZone: dead_zone_q <= pwdata[DeadW-1:0];
        RegOutMax:   out_max_q   <= pwdata[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      RegMode:     prdata = ApbDataW'(mode_q);
      RegGainP:    prdata = ApbDataW'($unsigned(gain_p_q));
      RegGainI:    prdata = ApbDataW'($unsigned(gain_i_q));
      RegGainD:    prdata = ApbDataW'($unsigned(gain_d_q));
      RegIntegLim: prdata = ApbDataW'(integ_lim_q);
      RegDeadZone: prdata = ApbDataW'(dead_zone_q);
      RegOutMax:   prdata = ApbDataW'(out_max_q);
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // handshake
  // ---------------------------------------------------------------------------

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign move       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (move) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  // ---------------------------------------------------------------------------
  // error and products
  // ---------------------------------------------------------------------------

  // differences against the last and the one before last error
  assign err   = ErrW'(in_q.reference) - ErrW'(in_q.feedback);
  assign diff1 = (ErrW+1)'(err) - (ErrW+1)'(err0_q);
  assign diff2 = (ErrW+2)'(err) - ((ErrW+2)'(err0_q) <<< 1) + (ErrW+2)'(err1_q);

  // operand choice per form, so one multiplier serves each gain
  assign op_p = mode_q ? diff1 : (ErrW+1)'(err);
  assign op_d = mode_q ? diff2 : (ErrW+2)'(diff1);

  assign prod_p = (ErrW+GainW+1)'(op_p) * (ErrW+GainW+1)'(gain_p_q);
  assign prod_i = (ErrW+GainW)'(err) * (ErrW+GainW)'(gain_i_q);
  assign prod_d = (ErrW+GainW+2)'(op_d) * (ErrW+GainW+2)'(gain_d_q);

  // dead zone, a zero width never holds
  assign dz_ext = signed'((ErrW+1)'(dead_zone_q));
  assign held   = ((ErrW+1)'(err) > -dz_ext) && ((ErrW+1)'(err) < dz_ext);

  // ---------------------------------------------------------------------------
  // integral, positional form
  // ---------------------------------------------------------------------------

  assign integ_sum = (IntegW+1)'(integ_q) + (IntegW+1)'(prod_i);

  // saturate at the accumulator width
  always_comb begin
    if (integ_sum[IntegW] != integ_sum[IntegW-1]) begin
      integ_sat = integ_sum[IntegW] ? {1'b1, {(IntegW-1){1'b0}}}
                                    : {1'b0, {(IntegW-1){1'b1}}};
    end else begin
      integ_sat = integ_sum[IntegW-1:0];
    end
  end

  // clamp to the programmed bound
  assign integ_lim = signed'(IntegW'(integ_lim_q) << FracBits);

  always_comb begin
    priority if (integ_sat > integ_lim) begin
      integ_clamp = integ_lim;
    end else if (integ_sat < -integ_lim) begin
      integ_clamp = -integ_lim;
    end else begin
      integ_clamp = integ_sat;
    end
  end

  always_comb begin
    if (mode_q) begin
      integ_d = integ_q;
    end else if (held) begin
      integ_d = integ_sat;
    end else begin
      integ_d = integ_clamp;
    end
  end

  // ---------------------------------------------------------------------------
  // output sum and clamps
  // ---------------------------------------------------------------------------

  always_comb begin
    if (mode_q) begin
      sum_v = SumW'(out_acc_q) + SumW'(prod_p) + SumW'(prod_i) + SumW'(prod_d);
    end else begin
      sum_v = SumW'(prod_p) + SumW'(integ_clamp) + SumW'(prod_d);
    end
  end

  // accumulator range as sign-extended bounds
  assign out_max_fx = signed'(SumW'(out_max_q) << FracBits);
  assign out_hi     = SumW'({1'b0, {(OutAccW-1){1'b1}}});
  assign out_lo     = ~out_hi;

  always_comb begin
    priority if (sum_v > out_max_fx) begin
      sum_clamp = out_max_fx;
    end else if (sum_v < -out_max_fx) begin
      sum_clamp = -out_max_fx;
    end else begin
      sum_clamp = sum_v;
    end
  end

  // accumulator range, only reached with a wide fraction
  always_comb begin
    priority if (sum_clamp > out_hi) begin
      out_acc_new = out_hi[OutAccW-1:0];
    end else if (sum_clamp < out_lo) begin
      out_acc_new = out_lo[OutAccW-1:0];
    end else begin
      out_acc_new = sum_clamp[OutAccW-1:0];
    end
  end

  assign out_acc_d   = held ? out_acc_q : out_acc_new;
  assign drive_shift = out_acc_d >>> FracBits;

  // ---------------------------------------------------------------------------
  // state update on each transfer into the result register
  // ---------------------------------------------------------------------------

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err0_q    <= '0;
      err1_q    <= '0;
      integ_q   <= '0;
      out_acc_q <= '0;
    end else if (move) begin
      err0_q    <= err;
      err1_q    <= err0_q;
      integ_q   <= integ_d;
      out_acc_q <= out_acc_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (move) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_q.drive <= drive_shift[DriveW-1:0];
      out_q.held  <= held;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // a taken result with nothing behind it leaves the output empty
  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !move) |=> !out_valid_q)
    else $error("result repeated after transfer");

  // a held step keeps the output accumulator
  a_held_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move && held) |=> (out_acc_q == $past(out_acc_q)))
    else $error("output accumulator changed on held step");

  // incremental form never touches the integral
  a_incr_integ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move && mode_q) |=> $stable(integ_q))
    else $error("integral changed in incremental form");

  // positional active step leaves the integral inside its bound
  a_integ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move && !mode_q && !held) |=>
      ((integ_q <= $past(integ_lim)) && (integ_q >= -$past(integ_lim))))
    else $error("integral outside its bound");

endmodule
